@@ sv/smd_pkg.sv @@
// smd_pkg: shared types and constants of the sensor matrix debouncer
// used by smd_row_update and sensor_matrix_debouncer_unit; no dependencies

package smd_pkg;

	localparam int ROWS   = 8;
	localparam int FILES  = 8;
	localparam int ROW_W  = 3;
	localparam int BUS_W  = 8;
	localparam int CONF_W = 4;

	localparam logic [CONF_W-1:0] THRESHOLD_RESET = CONF_W'(3);

	// one square: confidence counter and debounced state
	typedef struct packed {
		logic [CONF_W-1:0] conf;
		logic              active;
	} square_t;

	// one memory word holds a whole row of squares
	typedef square_t [FILES-1:0] row_word_t;

	// what the row update hands back to the top level
	typedef struct packed {
		row_word_t        word;
		logic [BUS_W-1:0] active_mask;
		logic [BUS_W-1:0] changed_mask;
	} row_result_t;

endpackage

@@ sv/smd_row_update.sv @@
// smd_row_update: per-row counter update of the debouncer, all files in parallel
// depends on smd_pkg

module smd_row_update
	import smd_pkg::*;
(
	input  row_word_t         word_in,
	input  logic [BUS_W-1:0]  idle_mask,
	input  logic [BUS_W-1:0]  detect_mask,
	input  logic [CONF_W-1:0] threshold,
	output row_result_t       result
);

	// saturating counter step and state flip for each file
	always_comb begin
		result = '0;
		for (int f = 0; f < FILES; f++) begin
			logic [CONF_W-1:0] c;
			logic              a;
			c = word_in[f].conf;
			a = word_in[f].active;
			if (idle_mask[f]) begin
				if (detect_mask[f]) begin
					if (c < threshold) begin
						c = c + CONF_W'(1);
					end
					if (c == threshold && !a) begin
						a = 1'b1;
						result.changed_mask[f] = 1'b1;
					end
				end else begin
					if (c != '0) begin
						c = c - CONF_W'(1);
					end
					if (c == '0 && a) begin
						a = 1'b0;
						result.changed_mask[f] = 1'b1;
					end
				end
			end
			result.word[f].conf   = c;
			result.word[f].active = a;
			result.active_mask[f] = a;
		end
	end

endmodule

@@ sv/sensor_matrix_debouncer_unit.sv @@
// sensor_matrix_debouncer_unit: top level of the sensor matrix debouncer
// depends on smd_pkg and smd_row_update
//
// Usage:
//   Input channel (in_valid / in_stall) carries one raw bus sample per request
//   with its row, the pre-selection bus level and first / last markers.
//   Only a request with last_sample set produces a result on the output
//   channel (out_valid / out_stall): the row, its debounced active bits,
//   the squares that flipped and a summary flag.
//   The row states live in an 8-entry memory, one 40-bit word per row.
//   A last sample reads its row at the accepting edge into the update stage,
//   which updates it and writes it back as it advances, and the result is
//   registered in the output register at that same edge.
//   Throughput is one request per cycle while in_stall is low; back-to-back
//   scans of a row take the just-written word from a forwarding register.
//   When the receiver stalls, the result holds in the output register, one
//   more result waits in the update stage, and in_stall rises only when
//   both are full and the receiver still stalls.
//   Reset clears the per-row valid bits, so every square reads as inactive
//   with a zero counter; no clearing pass is needed. The threshold resets
//   to 3 and must be written via cfg_wr_en / cfg_wr_data while idle (unchecked).

module sensor_matrix_debouncer_unit
	import smd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [CONF_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ROW_W-1:0]  row_index,
	input  logic [BUS_W-1:0]  sample_bus,
	input  logic [BUS_W-1:0]  idle_bus,
	input  logic              first_sample,
	input  logic              last_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ROW_W-1:0]  result_row,
	output logic [BUS_W-1:0]  active_mask,
	output logic [BUS_W-1:0]  changed_mask,
	output logic              any_changed
);

	logic [CONF_W-1:0] threshold_q;
	logic [BUS_W-1:0]  idle_latch_q;
	logic [BUS_W-1:0]  detect_acc_q;
	logic [BUS_W-1:0]  idle_next;
	logic [BUS_W-1:0]  detect_next;

	row_word_t         mem [ROWS];
	logic [ROWS-1:0]   row_vld_q;

	logic              valid_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [BUS_W-1:0]  idle_s1;
	logic [BUS_W-1:0]  detect_s1;
	row_word_t         rdata_s1;
	logic              rvld_s1;

	logic              fwd_valid_q;
	logic [ROW_W-1:0]  fwd_row_q;
	row_word_t         fwd_word_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  result_row_q;
	logic [BUS_W-1:0]  active_mask_q;
	logic [BUS_W-1:0]  changed_mask_q;

	logic              in_accept;
	logic              s1_adv;
	row_word_t         word_s1;
	row_result_t       upd;

	// handshake control
	assign s1_adv    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	// latch and detect accumulator for the row scan in progress
	always_comb begin
		if (first_sample) begin
			idle_next   = idle_bus;
			detect_next = ~sample_bus;
		end else begin
			idle_next   = idle_latch_q;
			detect_next = detect_acc_q & ~sample_bus;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_latch_q <= '0;
			detect_acc_q <= '0;
		end else if (in_accept) begin
			idle_latch_q <= idle_next;
			detect_acc_q <= detect_next;
		end
	end

	// update stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= last_sample;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// row memory read, issued at acceptance of a last sample
	always_ff @(posedge clk) begin
		if (in_accept && last_sample) begin
			rdata_s1  <= mem[row_index];
			row_s1    <= row_index;
			idle_s1   <= idle_next;
			detect_s1 <= detect_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else if (in_accept && last_sample) begin
			rvld_s1 <= row_vld_q[row_index];
		end
	end

	// pick forwarded word, memory word or the cleared value
	always_comb begin
		if (fwd_valid_q && fwd_row_q == row_s1) begin
			word_s1 = fwd_word_q;
		end else if (rvld_s1) begin
			word_s1 = rdata_s1;
		end else begin
			word_s1 = '0;
		end
	end

	smd_row_update u_row_update (
		.word_in     (word_s1),
		.idle_mask   (idle_s1),
		.detect_mask (detect_s1),
		.threshold   (threshold_q),
		.result      (upd)
	);

	// write back the updated row
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			mem[row_s1] <= upd.word;
			fwd_row_q   <= row_s1;
			fwd_word_q  <= upd.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q   <= '0;
			fwd_valid_q <= 1'b0;
		end else if (s1_adv) begin
			row_vld_q[row_s1] <= 1'b1;
			fwd_valid_q       <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			result_row_q   <= row_s1;
			active_mask_q  <= upd.active_mask;
			changed_mask_q <= upd.changed_mask;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_row   = result_row_q;
	assign active_mask  = active_mask_q;
	assign changed_mask = changed_mask_q;
	assign any_changed  = (changed_mask_q != '0);

	// a last sample always reaches the update stage
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && last_sample |=> valid_s1)
		else $error("last sample did not enter update stage");

	// a result waiting behind a stalled output is not dropped
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |=> valid_s1 && $stable(row_s1))
		else $error("update stage lost a pending result");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_row) &&
			$stable(active_mask) && $stable(changed_mask))
		else $error("stalled result changed");

	// updating a row marks it as holding written data
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> row_vld_q[$past(row_s1)] && fwd_valid_q)
		else $error("row valid bit not set after write back");

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench of sensor_matrix_debouncer_unit
// depends on smd_pkg and the debouncer RTL; predicts each row report from its
// own copy of the counters and compares every result field by field

`timescale 1ns / 1ps

module tb
	import smd_pkg::*;
();

	// one raw bus sample request and one expected row report
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [BUS_W-1:0] sample;
		logic [BUS_W-1:0] idle;
		logic             first;
		logic             last;
	} sample_req_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [BUS_W-1:0] active;
		logic [BUS_W-1:0] changed;
		logic             any;
	} row_report_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CONF_W-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [ROW_W-1:0]  row_index = '0;
	logic [BUS_W-1:0]  sample_bus = '0;
	logic [BUS_W-1:0]  idle_bus = '0;
	logic              first_sample = 1'b0;
	logic              last_sample = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [ROW_W-1:0]  result_row;
	logic [BUS_W-1:0]  active_mask;
	logic [BUS_W-1:0]  changed_mask;
	logic              any_changed;

	// predicted matrix state
	logic [CONF_W-1:0] conf_model [ROWS*FILES];
	logic              active_model [ROWS*FILES];
	logic [BUS_W-1:0]  idle_latch_model = '0;
	logic [BUS_W-1:0]  detect_model = '0;
	logic [CONF_W-1:0] threshold_model = THRESHOLD_RESET;

	sample_req_t sample_queue [$];
	row_report_t row_reports_due [$];
	sample_req_t in_flight;
	int          samples_queued = 0;
	int          samples_accepted = 0;
	int          mismatch_count = 0;
	int          send_gap = 0;
	int          stall_left = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;

	// per-row pattern of pressed files used by the random scans
	logic [BUS_W-1:0] held_files [ROWS];
	logic [ROW_W-1:0] hot_row;

	sensor_matrix_debouncer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.row_index    (row_index),
		.sample_bus   (sample_bus),
		.idle_bus     (idle_bus),
		.first_sample (first_sample),
		.last_sample  (last_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_row   (result_row),
		.active_mask  (active_mask),
		.changed_mask (changed_mask),
		.any_changed  (any_changed)
	);

	always #6 clk = ~clk;

	// accumulate one sample; on a last sample update the row and queue its report
	function automatic void qualify_sample(sample_req_t req);
		row_report_t       rep;
		logic [CONF_W-1:0] c;
		logic              a;
		int unsigned       sq;

		if (req.first) begin
			idle_latch_model = req.idle;
			detect_model = ~req.sample;
		end else begin
			detect_model = detect_model & ~req.sample;
		end
		if (!req.last)
			return;
		rep = '0;
		rep.row = req.row;
		for (int f = 0; f < FILES; f++) begin
			sq = req.row * FILES + f;
			c = conf_model[sq];
			a = active_model[sq];
			if (idle_latch_model[f]) begin
				if (detect_model[f]) begin
					if (c < threshold_model)
						c = c + CONF_W'(1);
					if (c == threshold_model && !a) begin
						a = 1'b1;
						rep.changed[f] = 1'b1;
					end
				end else begin
					if (c != '0)
						c = c - CONF_W'(1);
					if (c == '0 && a) begin
						a = 1'b0;
						rep.changed[f] = 1'b1;
					end
				end
				conf_model[sq] = c;
				active_model[sq] = a;
			end
			rep.active[f] = a;
		end
		rep.any = (rep.changed != '0);
		row_reports_due.push_back(rep);
	endfunction

	task automatic add_sample(input logic [ROW_W-1:0] row, input logic [BUS_W-1:0] sample,
			input logic [BUS_W-1:0] idle, input logic first, input logic last);
		sample_queue.push_back(sample_req_t'{row, sample, idle, first, last});
		samples_queued++;
	endtask

	task automatic write_threshold(input logic [CONF_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		threshold_model = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// wait until every request is taken and every report has come back
	task automatic drain();
		while (samples_accepted != samples_queued || row_reports_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// mostly well-formed row scans with content that persists across scans
	task automatic queue_random_scans(input int count);
		int               added;
		int               len;
		logic [ROW_W-1:0] row;
		logic [BUS_W-1:0] idle;
		logic [BUS_W-1:0] sample;
		logic             first;
		logic             last;

		added = 0;
		hot_row = ROW_W'($urandom_range(0, ROWS - 1));
		while (added < count) begin
			if ($urandom_range(0, 9) == 0) begin
				add_sample(ROW_W'($urandom_range(0, ROWS - 1)), BUS_W'($urandom),
					BUS_W'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				added++;
			end else begin
				row = $urandom_range(0, 1) ? hot_row : ROW_W'($urandom_range(0, ROWS - 1));
				len = $urandom_range(1, 4);
				if ($urandom_range(0, 15) == 0)
					held_files[row] = BUS_W'($urandom);
				idle = ($urandom_range(0, 3) == 0) ? BUS_W'($urandom) : {BUS_W{1'b1}};
				for (int k = 0; k < len; k++) begin
					sample = ~held_files[row];
					if ($urandom_range(0, 7) == 0)
						sample = sample | BUS_W'($urandom);
					first = (k == 0);
					last = (k == len - 1);
					// occasionally broken scan: a marker goes missing
					if ($urandom_range(0, 19) == 0)
						first = 1'b0;
					if ($urandom_range(0, 19) == 0)
						last = 1'b0;
					add_sample(row, sample, idle, first, last);
					added++;
				end
			end
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				qualify_sample(in_flight);
				samples_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					in_flight = sample_queue.pop_front();
					row_index <= in_flight.row;
					sample_bus <= in_flight.sample;
					idle_bus <= in_flight.idle;
					first_sample <= in_flight.first;
					last_sample <= in_flight.last;
					in_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : $urandom_range(0, 12);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		row_report_t exp_rep;

		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (row_reports_due.size() == 0) begin
					$error("result for row %0d with no report due", result_row);
					mismatch_count++;
				end else begin
					exp_rep = row_reports_due.pop_front();
					if (result_row !== exp_rep.row) begin
						$error("result_row: expected %0d, actual %0d", exp_rep.row, result_row);
						mismatch_count++;
					end
					if (active_mask !== exp_rep.active) begin
						$error("active_mask: expected %h, actual %h", exp_rep.active, active_mask);
						mismatch_count++;
					end
					if (changed_mask !== exp_rep.changed) begin
						$error("changed_mask: expected %h, actual %h", exp_rep.changed,
							changed_mask);
						mismatch_count++;
					end
					if (any_changed !== exp_rep.any) begin
						$error("any_changed: expected %b, actual %b", exp_rep.any, any_changed);
						mismatch_count++;
					end
				end
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				stall_left = recv_calm ? 0 : $urandom_range(0, 12);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	// stimulus sequence
	initial begin
		logic [CONF_W-1:0] phase_threshold [6];

		phase_threshold = '{4'd15, 4'd1, 4'd8, 4'd15, 4'd2, 4'd5};
		for (int i = 0; i < ROWS * FILES; i++) begin
			conf_model[i] = '0;
			active_model[i] = 1'b0;
		end
		for (int r = 0; r < ROWS; r++)
			held_files[r] = BUS_W'($urandom);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold: build row 0 up to active with single-sample scans
		add_sample(3'd0, 8'h00, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd0, 8'h00, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd0, 8'h00, 8'hFF, 1'b1, 1'b1);
		// nothing low in every sample of row 7
		add_sample(3'd7, 8'hFF, 8'hFF, 1'b1, 1'b0);
		add_sample(3'd7, 8'h00, 8'hFF, 1'b0, 1'b0);
		add_sample(3'd7, 8'h00, 8'hFF, 1'b0, 1'b1);
		// multi-sample scan leaving only files 6 and 7 detected
		add_sample(3'd7, 8'h0F, 8'hFF, 1'b1, 1'b0);
		add_sample(3'd7, 8'h3C, 8'hFF, 1'b0, 1'b0);
		add_sample(3'd7, 8'h00, 8'hFF, 1'b0, 1'b1);
		// last samples without a first reuse the held latch and accumulator
		add_sample(3'd7, 8'h00, 8'h00, 1'b0, 1'b1);
		add_sample(3'd7, 8'h00, 8'h00, 1'b0, 1'b1);
		// stray middle sample, then a scan ending on it
		add_sample(3'd3, 8'h00, 8'hFF, 1'b0, 1'b0);
		add_sample(3'd3, 8'h00, 8'hFF, 1'b0, 1'b1);
		// release row 0 through partial idle masks
		add_sample(3'd0, 8'hFF, 8'hAA, 1'b1, 1'b1);
		add_sample(3'd0, 8'h00, 8'h00, 1'b1, 1'b1);
		add_sample(3'd0, 8'hFF, 8'h55, 1'b1, 1'b1);
		add_sample(3'd0, 8'hFF, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd0, 8'hFF, 8'hFF, 1'b1, 1'b1);
		drain();

		// zero threshold: fresh squares flip on the first detection
		write_threshold(4'd0);
		add_sample(3'd5, 8'h00, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd5, 8'hFF, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd5, 8'hA5, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd7, 8'h00, 8'hFF, 1'b1, 1'b1);
		add_sample(3'd7, 8'hFF, 8'hFF, 1'b1, 1'b1);
		drain();

		// random phases across several thresholds, extremes included
		for (int p = 0; p < 6; p++) begin
			write_threshold(p == 5 ? CONF_W'($urandom_range(1, 15)) : phase_threshold[p]);
			queue_random_scans(100);
			drain();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// run limit
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sensor_matrix_debouncer_unit.f @@
sv/smd_pkg.sv
sv/smd_row_update.sv
sv/sensor_matrix_debouncer_unit.sv
tb/sv/tb.sv
